### sv/rths_pkg.sv
// ----------------------------------------------------------------------------
// rths_pkg
// Types, constants and tables shared by the rotate-to-heading speed profile.
// ----------------------------------------------------------------------------
package rths_pkg;

	localparam int DIV_W = 31;

	localparam logic signed [19:0] PI_Q13     = 20'sd25736;
	localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
	localparam logic signed [19:0] PI_Q16     = 20'sd205887;

	localparam logic [2:0] CFG_AIM_MODE       = 3'd0;
	localparam logic [2:0] CFG_TARGET_X       = 3'd1;
	localparam logic [2:0] CFG_TARGET_Y       = 3'd2;
	localparam logic [2:0] CFG_TARGET_HEADING = 3'd3;
	localparam logic [2:0] CFG_MAX_SPEED      = 3'd4;
	localparam logic [2:0] CFG_MAX_ACCEL      = 3'd5;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CORDIC,
		OP_ERR,
		OP_MUL_VV,
		OP_DIV_ZONE,
		OP_ZONE,
		OP_MUL_ADA,
		OP_MUL_SS,
		OP_MUL_AA,
		OP_BRAKE,
		OP_RAMP,
		OP_MUL_ADV,
		OP_DIV_Q,
		OP_PROP,
		OP_ZERO
	} op_t;

	typedef struct packed {
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic aim_fixed;
		logic cordic_last;
		logic div_busy;
		logic v_zero;
		logic ad_gt_zone;
		logic zone_zero;
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_ERR,
		ST_MVV,
		ST_DZ_GO,
		ST_DZ_WAIT,
		ST_ZONE,
		ST_DECIDE,
		ST_MADA,
		ST_MSS,
		ST_MAA,
		ST_BRAKE,
		ST_RAMP,
		ST_MADV,
		ST_DQ_GO,
		ST_DQ_WAIT,
		ST_PROP,
		ST_ZERO,
		ST_OUT
	} state_t;

	// atan(2^-i) at 2^16 per radian
	function automatic logic [16:0] atan_q16(input logic [4:0] i);
		logic [16:0] r;
		unique case (i)
			5'd0:  r = 17'd51472;
			5'd1:  r = 17'd30386;
			5'd2:  r = 17'd16055;
			5'd3:  r = 17'd8150;
			5'd4:  r = 17'd4091;
			5'd5:  r = 17'd2047;
			5'd6:  r = 17'd1024;
			5'd7:  r = 17'd512;
			5'd8:  r = 17'd256;
			5'd9:  r = 17'd128;
			5'd10: r = 17'd64;
			5'd11: r = 17'd32;
			5'd12: r = 17'd16;
			5'd13: r = 17'd8;
			5'd14: r = 17'd4;
			5'd15: r = 17'd2;
			5'd16: r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

### sv/rths_div.sv
// ----------------------------------------------------------------------------
// rths_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rths_div #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### sv/rths_dp.sv
// ----------------------------------------------------------------------------
// rths_dp
// Datapath: configuration registers, CORDIC bearing, heading error, shared
// multiplier, divider and the kept angular speed.
// ----------------------------------------------------------------------------
module rths_dp #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic [47:0]     pose_data,
	input  rths_pkg::cmd_t  cmd,
	output rths_pkg::stat_t stat,
	output logic [15:0]     turn_speed
);
	import rths_pkg::*;

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	logic               aim_mode_q;
	logic signed [15:0] tx_q, ty_q, th_q;
	logic [14:0]        vmax_q, amax_q;

	logic signed [15:0] ph_q;
	logic signed [27:0] cx_q, cy_q;
	logic signed [19:0] cz_q;
	logic [IW-1:0]      it_q;
	logic               zflag_q;
	logic signed [15:0] d_q;
	logic [14:0]        ad_q;
	logic [14:0]        a_q;
	logic [31:0]        prod_q;
	logic [29:0]        zone_q;
	logic [29:0]        lhs_q;
	logic [30:0]        ss_q;
	logic               brake_q;
	logic signed [15:0] speed_q;
	logic [15:0]        out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_mode_q <= 1'b1;
			tx_q       <= '0;
			ty_q       <= '0;
			th_q       <= '0;
			vmax_q     <= '0;
			amax_q     <= 15'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AIM_MODE:       aim_mode_q <= cfg_data[0];
				CFG_TARGET_X:       tx_q       <= cfg_data;
				CFG_TARGET_Y:       ty_q       <= cfg_data;
				CFG_TARGET_HEADING: th_q       <= cfg_data;
				CFG_MAX_SPEED:      vmax_q     <= cfg_data[14:0];
				CFG_MAX_ACCEL:      amax_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// load: differences to the target, folded into the right half plane
	logic signed [15:0] px, py;
	logic signed [16:0] dx, dy;
	logic signed [27:0] x0, y0;
	assign px = pose_data[15:0];
	assign py = pose_data[31:16];
	assign dx = {tx_q[15], tx_q} - {px[15], px};
	assign dy = {ty_q[15], ty_q} - {py[15], py};
	assign x0 = {{3{dx[16]}}, dx, 8'b0};
	assign y0 = {{3{dy[16]}}, dy, 8'b0};

	// cordic step
	logic signed [27:0] xs, ys;
	logic signed [19:0] atn;
	assign xs  = cx_q >>> it_q;
	assign ys  = cy_q >>> it_q;
	assign atn = {3'b0, atan_q16(5'(it_q))};

	// heading error
	logic signed [19:0] bearing, aim, d0, dw;
	assign bearing = (cz_q + 20'sd4) >>> 3;
	always_comb begin
		if (aim_mode_q)
			aim = {{4{th_q[15]}}, th_q};
		else if (zflag_q)
			aim = '0;
		else
			aim = bearing;
		d0 = aim - {{4{ph_q[15]}}, ph_q};
		if (d0 >= PI_Q13)
			dw = d0 - TWO_PI_Q13;
		else if (d0 < -PI_Q13)
			dw = d0 + TWO_PI_Q13;
		else
			dw = d0;
	end

	// shared multiplier
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] mul_p;
	always_comb begin
		unique case (cmd.op)
			OP_MUL_VV:  begin mul_a = {2'b0, vmax_q}; mul_b = {2'b0, vmax_q}; end
			OP_MUL_ADA: begin mul_a = {2'b0, ad_q};   mul_b = {2'b0, a_q};    end
			OP_MUL_SS:  begin mul_a = {speed_q[15], speed_q}; mul_b = {speed_q[15], speed_q}; end
			OP_MUL_AA:  begin mul_a = {2'b0, a_q};    mul_b = {2'b0, a_q};    end
			OP_MUL_ADV: begin mul_a = {2'b0, ad_q};   mul_b = {2'b0, vmax_q}; end
			default:    begin mul_a = '0;             mul_b = '0;             end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// divider
	logic             div_start;
	logic [DIV_W-1:0] div_den;
	logic [DIV_W-1:0] div_quo;
	logic             div_busy;
	assign div_start = (cmd.op == OP_DIV_ZONE) || (cmd.op == OP_DIV_Q);
	assign div_den   = (cmd.op == OP_DIV_ZONE) ? {15'b0, a_q, 1'b0} : {1'b0, zone_q};

	rths_div #(.W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[DIV_W-1:0]),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// braking test and ramp
	logic signed [32:0] rhs;
	assign rhs = $signed({2'b0, ss_q}) - $signed({2'b0, prod_q[29:0], 1'b0});

	logic signed [17:0] s18, a18, v18, a2, nr;
	always_comb begin
		s18 = {{2{speed_q[15]}}, speed_q};
		a18 = {3'b0, a_q};
		v18 = {3'b0, vmax_q};
		a2  = a18 <<< 1;
		if (!d_q[15]) begin
			if (!brake_q)
				nr = s18 + a18;
			else if (s18 > a2)
				nr = s18 - a2;
			else
				nr = s18;
			if (nr > v18)
				nr = v18;
		end else begin
			if (!brake_q)
				nr = s18 - a18;
			else if (s18 < -a2)
				nr = s18 + a2;
			else
				nr = s18;
			if (nr < -v18)
				nr = -v18;
		end
	end

	logic signed [15:0] nr_sat;
	always_comb begin
		if (nr > 18'sd32767)
			nr_sat = 16'sh7fff;
		else if (nr < -18'sd32768)
			nr_sat = 16'sh8000;
		else
			nr_sat = nr[15:0];
	end

	logic signed [15:0] q16;
	assign q16 = {1'b0, div_quo[14:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			speed_q <= '0;
		else if (cmd.op == OP_RAMP)
			speed_q <= nr_sat;
		else if (cmd.op == OP_PROP)
			speed_q <= d_q[15] ? -q16 : q16;
		else if (cmd.op == OP_ZERO)
			speed_q <= '0;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				ph_q    <= pose_data[47:32];
				it_q    <= '0;
				zflag_q <= (dx == 17'sd0) && (dy == 17'sd0);
				if (x0 < 0) begin
					cx_q <= -x0;
					cy_q <= -y0;
					cz_q <= (y0 >= 0) ? PI_Q16 : -PI_Q16;
				end else begin
					cx_q <= x0;
					cy_q <= y0;
					cz_q <= '0;
				end
			end
			OP_CORDIC: begin
				it_q <= it_q + 1'b1;
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atn;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atn;
				end
			end
			OP_ERR: begin
				d_q  <= dw[15:0];
				ad_q <= dw[19] ? 15'(-dw) : dw[14:0];
				a_q  <= (amax_q == '0) ? 15'd1 : amax_q;
			end
			OP_MUL_VV, OP_MUL_ADV: prod_q <= mul_p[31:0];
			OP_MUL_ADA: prod_q <= mul_p[31:0];
			OP_MUL_SS: begin
				lhs_q  <= prod_q[29:0];
				prod_q <= mul_p[31:0];
			end
			OP_MUL_AA: begin
				ss_q   <= prod_q[30:0];
				prod_q <= mul_p[31:0];
			end
			OP_BRAKE: brake_q <= $signed({3'b0, lhs_q}) < rhs;
			OP_ZONE:  zone_q  <= div_quo[29:0];
			default: ;
		endcase
		if (cmd.out_load)
			out_q <= speed_q;
	end

	assign stat.aim_fixed   = aim_mode_q;
	assign stat.cordic_last = (it_q == IW'(CORDIC_STEPS - 1));
	assign stat.div_busy    = div_busy;
	assign stat.v_zero      = (vmax_q == '0);
	assign stat.ad_gt_zone  = ({15'b0, ad_q} > zone_q);
	assign stat.zone_zero   = (zone_q == '0);
	assign turn_speed       = out_q;

endmodule

### sv/rths_ctrl.sv
// ----------------------------------------------------------------------------
// rths_ctrl
// Sequencer: walks one pose word through the datapath and owns both
// handshakes.
// ----------------------------------------------------------------------------
module rths_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  rths_pkg::stat_t stat,
	output rths_pkg::cmd_t  cmd
);
	import rths_pkg::*;

	state_t state_q, state_d;
	logic   mvalid_q, mvalid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mvalid_q <= mvalid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		s_tready     = 1'b0;
		mvalid_d     = mvalid_q && !m_tready;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = stat.aim_fixed ? ST_ERR : ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				cmd.op = OP_CORDIC;
				if (stat.cordic_last)
					state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.op  = OP_ERR;
				state_d = ST_MVV;
			end
			ST_MVV: begin
				cmd.op  = OP_MUL_VV;
				state_d = ST_DZ_GO;
			end
			ST_DZ_GO: begin
				cmd.op  = OP_DIV_ZONE;
				state_d = ST_DZ_WAIT;
			end
			ST_DZ_WAIT: begin
				if (!stat.div_busy)
					state_d = ST_ZONE;
			end
			ST_ZONE: begin
				cmd.op  = OP_ZONE;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (stat.v_zero)
					state_d = ST_ZERO;
				else if (stat.ad_gt_zone)
					state_d = ST_MADA;
				else if (stat.zone_zero)
					state_d = ST_ZERO;
				else
					state_d = ST_MADV;
			end
			ST_MADA: begin
				cmd.op  = OP_MUL_ADA;
				state_d = ST_MSS;
			end
			ST_MSS: begin
				cmd.op  = OP_MUL_SS;
				state_d = ST_MAA;
			end
			ST_MAA: begin
				cmd.op  = OP_MUL_AA;
				state_d = ST_BRAKE;
			end
			ST_BRAKE: begin
				cmd.op  = OP_BRAKE;
				state_d = ST_RAMP;
			end
			ST_RAMP: begin
				cmd.op  = OP_RAMP;
				state_d = ST_OUT;
			end
			ST_MADV: begin
				cmd.op  = OP_MUL_ADV;
				state_d = ST_DQ_GO;
			end
			ST_DQ_GO: begin
				cmd.op  = OP_DIV_Q;
				state_d = ST_DQ_WAIT;
			end
			ST_DQ_WAIT: begin
				if (!stat.div_busy)
					state_d = ST_PROP;
			end
			ST_PROP: begin
				cmd.op  = OP_PROP;
				state_d = ST_OUT;
			end
			ST_ZERO: begin
				cmd.op  = OP_ZERO;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!mvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					mvalid_d     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = mvalid_q;

endmodule

### sv/rotate_to_heading_speed_profile_core.sv
// ----------------------------------------------------------------------------
// rotate_to_heading_speed_profile_core
// Angular speed profile: pose word in, commanded turn speed word out.
// ----------------------------------------------------------------------------
// One pose word is processed at a time. The speed is forced to zero for zero
// maximum speed or an empty end zone; otherwise it follows the ramp or, in
// the proportional end zone, is set from a division. When aiming at a target
// point, the CORDIC runs first, one iteration per cycle. Each division (zone
// size always, proportional speed only in the end zone) uses the shared
// radix-2 divider: a start state, then a wait state until it is no longer
// busy. The result is loaded into the output register as the sequencer
// returns to idle, where the next pose word can be accepted.
// One result can wait in the output register; if it is still unread when the
// next result is done, that result and the input are held until it is read.
module rotate_to_heading_speed_profile_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pose_x, pose_y, pose_heading
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // turn_speed
);
	import rths_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rths_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rths_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pose_data  (s_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.turn_speed (m_tdata)
	);

endmodule

### dv/rotate_to_heading_speed_profile_core_tb.sv
// ----------------------------------------------------------------------------
// rotate_to_heading_speed_profile_core_tb
// Drives pose words and register writes, and checks each turn speed against
// an in-bench model of the profile (CORDIC bearing, zone, ramp and brake).
// ----------------------------------------------------------------------------
module rotate_to_heading_speed_profile_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rths_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam int N_RANDOM = 1530;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [2:0] CFG_UNMAPPED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	rotate_to_heading_speed_profile_core #(.CORDIC_STEPS(CORDIC_STEPS)) dut (.*);

	always #1 clk = ~clk;

	// profile settings, mirrored from the writes, and the model's kept speed
	logic        aim_fixed;
	longint      tgt_x, tgt_y, tgt_hdg, spd_max, acc_max, spd_kept;

	logic [15:0] speed_q[$];
	int          n_bad = 0;
	longint      cycles = 0;
	bit          rx_hold_off = 1'b0;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, xs, ys;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = shr(x, i);
			ys = shr(y, i);
			if (y > 0) begin
				x = x + ys; y = y - xs; z += longint'(atan_q16(i[4:0]));
			end else begin
				x = x - ys; y = y + xs; z -= longint'(atan_q16(i[4:0]));
			end
		end
		return shr(z + 4, 3);
	endfunction

	function automatic logic [15:0] next_speed(logic [47:0] pose);
		longint px, py, ph, a, aim, d, ad, zone, s, q;
		bit brake;
		px = longint'($signed(pose[15:0]));
		py = longint'($signed(pose[31:16]));
		ph = longint'($signed(pose[47:32]));
		a = (acc_max == 0) ? 1 : acc_max;
		s = spd_kept;
		aim = aim_fixed ? tgt_hdg : bearing(tgt_x - px, tgt_y - py);
		d = aim - ph;
		while (d >= longint'(PI_Q13)) d -= longint'(TWO_PI_Q13);
		while (d < -longint'(PI_Q13)) d += longint'(TWO_PI_Q13);
		ad = d < 0 ? -d : d;
		zone = (spd_max * spd_max) / (2 * a);
		if (spd_max == 0) s = 0;
		else if (ad > zone) begin
			brake = ad * a < s * s - 2 * a * a;
			if (d > 0) begin
				if (!brake) s += a;
				else if (s > 2 * a) s -= 2 * a;
				if (s > spd_max) s = spd_max;
			end else begin
				if (!brake) s -= a;
				else if (s < -2 * a) s += 2 * a;
				if (s < -spd_max) s = -spd_max;
			end
		end else if (zone == 0) s = 0;
		else begin
			q = (ad * spd_max) / zone;
			s = (d < 0) ? -q : q;
		end
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		spd_kept = s;
		return s[15:0];
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_AIM_MODE:       aim_fixed = val[0];
			CFG_TARGET_X:       tgt_x = longint'($signed(val));
			CFG_TARGET_Y:       tgt_y = longint'($signed(val));
			CFG_TARGET_HEADING: tgt_hdg = longint'($signed(val));
			CFG_MAX_SPEED:      spd_max = longint'(val[14:0]);
			CFG_MAX_ACCEL:      acc_max = longint'(val[14:0]);
			default: ;
		endcase
	endtask

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60))
		                                : int'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(negedge clk);
	endtask

	// wait for the pipeline to drain before touching the registers
	task automatic drain();
		while (speed_q.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic send_pose(logic [47:0] pose, bit check_known, logic [15:0] known);
		logic [15:0] exp_v;
		exp_v = next_speed(pose);
		if (check_known && exp_v !== known) begin
			n_bad++;
			if (n_bad <= 10)
				$display("table mismatch: pose %h expected %h model %h", pose, known, exp_v);
		end
		speed_q.push_back(exp_v);
		s_tdata <= pose;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		// blocking, so a following word may raise it again in this step
		s_tvalid = 1'b0;
	endtask

	function automatic logic [15:0] rnd_hdg();
		return 16'($signed($urandom_range(0, 51471)) - 25736);
	endfunction

	function automatic logic [47:0] rnd_pose();
		logic [47:0] p;
		p = 48'({$urandom, $urandom});
		if ($urandom_range(0, 3) != 0) p[47:32] = rnd_hdg();
		return p;
	endfunction

	typedef struct {
		logic [47:0] pose;
		bit          known;
		logic [15:0] speed;
	} pose_row_t;

	pose_row_t table_rows[5] = '{
		'{48'h0000_0000_0000, 1'b1, 16'h0000},
		'{48'h6488_7FFF_8000, 1'b1, 16'h0000},
		'{48'h9B78_8000_7FFF, 1'b1, 16'h0000},
		'{48'h7FFF_0000_0000, 1'b1, 16'h0000},
		'{48'h8000_FFFF_FFFF, 1'b1, 16'h0000}
	};

	pose_row_t more_rows[9] = '{
		'{48'h0000_0000_0000, 1'b0, 16'h0000},
		'{48'h9B78_0000_0000, 1'b0, 16'h0000},
		'{48'h6487_0000_0000, 1'b0, 16'h0000},
		'{48'h7FFF_7FFF_7FFF, 1'b0, 16'h0000},
		'{48'h8000_8000_8000, 1'b0, 16'h0000},
		'{48'h0100_0000_0000, 1'b0, 16'h0000},
		'{48'hFF00_0000_0000, 1'b0, 16'h0000},
		'{48'h0000_0000_0000, 1'b0, 16'h0000},
		'{48'h0001_0000_0000, 1'b0, 16'h0000}
	};

	// receiver: random stalls, compare every word with the oldest expectation
	always @(negedge clk) begin
		if (arst_n) m_tready <= rx_hold_off ? 1'b0 : ($urandom_range(0, 4) != 0);
	end

	always @(posedge clk) begin
		logic [15:0] e;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (speed_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected turn speed %h", m_tdata);
			end else begin
				e = speed_q.pop_front();
				if (m_tdata !== e) begin
					n_bad++;
					if (n_bad <= 10)
						$display("turn_speed mismatch: expected %h actual %h", e, m_tdata);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// occasional long receiver stall
	always begin
		repeat ($urandom_range(200, 2000)) @(negedge clk);
		rx_hold_off = 1'b1;
		repeat ($urandom_range(20, 200)) @(negedge clk);
		rx_hold_off = 1'b0;
	end

	initial begin
		aim_fixed = 1'b1; tgt_x = 0; tgt_y = 0; tgt_hdg = 0;
		spd_max = 0; acc_max = 1; spd_kept = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero maximum speed gives zero
		foreach (table_rows[i]) send_pose(table_rows[i].pose, table_rows[i].known, table_rows[i].speed);
		drain();
		write_reg(CFG_MAX_SPEED, 16'h7FFF);
		write_reg(CFG_MAX_ACCEL, 16'h0000);
		write_reg(CFG_TARGET_HEADING, 16'h6487);
		write_reg(CFG_UNMAPPED, 16'h1234);
		foreach (more_rows[i]) send_pose(more_rows[i].pose, 1'b0, 16'h0);
		drain();
		write_reg(CFG_AIM_MODE, 16'h0000);
		write_reg(CFG_TARGET_X, 16'h7FFF);
		write_reg(CFG_TARGET_Y, 16'h8000);
		write_reg(CFG_MAX_ACCEL, 16'h7FFF);
		write_reg(CFG_MAX_SPEED, 16'h0001);
		foreach (more_rows[i]) send_pose(more_rows[i].pose, 1'b0, 16'h0);

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k % 100 == 0) begin
				drain();
				write_reg(CFG_AIM_MODE, 16'($urandom_range(0, 1)));
				write_reg(CFG_TARGET_X, 16'($urandom));
				write_reg(CFG_TARGET_Y, 16'($urandom));
				write_reg(CFG_TARGET_HEADING, $urandom_range(0, 7) == 0 ? 16'($urandom) : rnd_hdg());
				case ($urandom_range(0, 3))
					0: write_reg(CFG_MAX_SPEED, 16'($urandom));
					1: write_reg(CFG_MAX_SPEED, 16'($urandom_range(0, 2)));
					default: write_reg(CFG_MAX_SPEED, 16'($urandom_range(50, 3000)));
				endcase
				case ($urandom_range(0, 3))
					0: write_reg(CFG_MAX_ACCEL, 16'($urandom));
					1: write_reg(CFG_MAX_ACCEL, 16'($urandom_range(0, 1)));
					default: write_reg(CFG_MAX_ACCEL, 16'($urandom_range(1, 200)));
				endcase
			end
			gap();
			send_pose(rnd_pose(), 1'b0, 16'h0);
		end

		while (speed_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (n_bad == 0 && speed_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### sim.f
sv/rths_pkg.sv
sv/rths_div.sv
sv/rths_dp.sv
sv/rths_ctrl.sv
sv/rotate_to_heading_speed_profile_core.sv
dv/rotate_to_heading_speed_profile_core_tb.sv
